>>> src/feistel16_cbc_cipher_assert.svh
// Assertion macros for the feistel16_cbc_cipher block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef FEISTEL16_CBC_CIPHER_ASSERT_SVH
`define FEISTEL16_CBC_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define F16CBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, including those in reset.
`define F16CBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define F16CBC_ASSERT(lbl, clk, rstn, prop, msg)
`define F16CBC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> src/f16cbc_pkg.sv
package f16cbc_pkg;

    localparam int MAX_ROUNDS = 16;
    localparam int BLOCK_W    = 16;
    localparam int HALF_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

    // One output half of the network written as a linear combination of the
    // input halves and the round subkeys (over GF(2)).
    typedef struct packed {
        logic                  from_left;
        logic                  from_right;
        logic [MAX_ROUNDS-1:0] key_sel;
    } half_coef_t;

    typedef struct packed {
        half_coef_t left;
        half_coef_t right;
    } block_coef_t;

    // Every round is left ^= right ^ subkey followed by a swap, so the whole
    // network is linear. Tracking the coefficients symbolically here turns the
    // round chain into a flat XOR of selected terms in hardware.
    function automatic block_coef_t feistel_coef(input int rounds);
        half_coef_t  lft;
        half_coef_t  rgt;
        half_coef_t  tmp;
        block_coef_t coef;
        lft            = '0;
        lft.from_left  = 1'b1;
        rgt            = '0;
        rgt.from_right = 1'b1;
        for (int r = 0; r < MAX_ROUNDS; r++) begin
            if (r < rounds) begin
                tmp            = lft ^ rgt;
                tmp.key_sel[r] = 1'b1;
                lft            = rgt;
                rgt            = tmp;
            end
        end
        // The final swap undoes the swap of the last round.
        coef.left  = rgt;
        coef.right = lft;
        return coef;
    endfunction

endpackage

>>> src/feistel16_cbc_cipher.sv
// 16-bit Feistel block cipher in CBC mode.
//
// Input stream (s_*): one 16-bit block per transaction in s_tdata; s_tuser
// marks the first block of a message, which chains from the init vector.
// Output stream (m_*): one 16-bit result block per input transaction, in order.
// Configuration: cfg_wr_en writes cfg_data to the register at cfg_index
// (0 key, 1 init vector, 2 decrypt mode); other indexes are ignored.
// Change the configuration only while no block is in flight.
//
// An accepted input block passes through the input register, then the
// flattened XOR network and CBC chaining into the output register. The
// chaining register is updated as each block moves to the output, so one
// block per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its block and the
// input register still takes one more; s_tready drops only when both are full.
// Reset clears the configuration, the chaining value and both valid flags.
`include "feistel16_cbc_cipher_assert.svh"

module feistel16_cbc_cipher #(
    parameter int ROUND_COUNT = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [f16cbc_pkg::BLOCK_W-1:0]      s_tdata,   // [15:0] data_block
    input  logic                                s_tuser,   // [0] first_block

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [f16cbc_pkg::BLOCK_W-1:0]      m_tdata,   // [15:0] result_block

    input  logic                                cfg_wr_en,
    input  logic [f16cbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [f16cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam f16cbc_pkg::block_coef_t COEF = f16cbc_pkg::feistel_coef(ROUND_COUNT);

    logic [f16cbc_pkg::BLOCK_W-1:0] key_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] iv_reg;
    logic                           decrypt_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] chain_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] chain_next;

    logic                           in_valid_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] in_data_reg;
    logic                           in_first_reg;

    logic                           out_valid_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] out_data_reg;
    logic [f16cbc_pkg::BLOCK_W-1:0] out_data_next;

    logic                           load_out;
    logic                           load_in;

    logic [f16cbc_pkg::HALF_W-1:0]  subkey [f16cbc_pkg::MAX_ROUNDS];
    logic [f16cbc_pkg::BLOCK_W-1:0] chain_sel;
    logic [f16cbc_pkg::BLOCK_W-1:0] net_in;
    logic [f16cbc_pkg::BLOCK_W-1:0] net_out;

    assign load_out = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load_out;
    assign load_in  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            iv_reg      <= '0;
            decrypt_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                f16cbc_pkg::REG_KEY:          key_reg     <= cfg_data;
                f16cbc_pkg::REG_INIT_VECTOR:  iv_reg      <= cfg_data;
                f16cbc_pkg::REG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Subkey for round r is the low byte of the key rotated right; decryption
    // walks the rotations in reverse.
    always_comb begin
        logic [2*f16cbc_pkg::BLOCK_W-1:0] key_dup;
        logic [3:0]                       amount;
        key_dup = {key_reg, key_reg};
        for (int r = 0; r < f16cbc_pkg::MAX_ROUNDS; r++) begin
            if (decrypt_reg && (r < ROUND_COUNT)) begin
                amount = 4'(ROUND_COUNT - 1 - r);
            end else begin
                amount = 4'(r);
            end
            subkey[r] = key_dup[amount +: f16cbc_pkg::HALF_W];
        end
    end

    always_comb begin
        chain_sel = in_first_reg ? iv_reg : chain_reg;
        net_in    = decrypt_reg ? in_data_reg : (in_data_reg ^ chain_sel);
    end

    // Flattened Feistel network: each output half is an XOR of fixed terms.
    always_comb begin
        logic [f16cbc_pkg::HALF_W-1:0] l_in;
        logic [f16cbc_pkg::HALF_W-1:0] r_in;
        logic [f16cbc_pkg::HALF_W-1:0] l_out;
        logic [f16cbc_pkg::HALF_W-1:0] r_out;
        l_in  = net_in[f16cbc_pkg::BLOCK_W-1:f16cbc_pkg::HALF_W];
        r_in  = net_in[f16cbc_pkg::HALF_W-1:0];
        l_out = (COEF.left.from_left   ? l_in : '0) ^ (COEF.left.from_right  ? r_in : '0);
        r_out = (COEF.right.from_left  ? l_in : '0) ^ (COEF.right.from_right ? r_in : '0);
        for (int r = 0; r < f16cbc_pkg::MAX_ROUNDS; r++) begin
            if (COEF.left.key_sel[r]) begin
                l_out = l_out ^ subkey[r];
            end
            if (COEF.right.key_sel[r]) begin
                r_out = r_out ^ subkey[r];
            end
        end
        net_out = {l_out, r_out};
    end

    always_comb begin
        if (decrypt_reg) begin
            out_data_next = net_out ^ chain_sel;
            chain_next    = in_data_reg;
        end else begin
            out_data_next = net_out;
            chain_next    = net_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end else begin
            if (load_in) begin
                in_valid_reg <= 1'b1;
            end else if (load_out) begin
                in_valid_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                chain_reg     <= chain_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (load_out) begin
            out_data_reg <= out_data_next;
        end
    end

    `F16CBC_ASSERT(a_enc_chain, aclk, aresetn, (load_out && !decrypt_reg) |=> (chain_reg == out_data_reg), "encrypt chain does not match the ciphertext sent")
    `F16CBC_ASSERT(a_dec_chain, aclk, aresetn, (load_out && decrypt_reg) |=> (chain_reg == $past(in_data_reg)), "decrypt chain does not match the ciphertext received")
    `F16CBC_ASSERT(a_in_hold, aclk, aresetn, (in_valid_reg && !load_out) |=> (in_valid_reg && $stable(in_data_reg)), "stalled input block was lost or changed")
    `F16CBC_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!in_valid_reg && !out_valid_reg && (chain_reg == '0)), "reset did not clear the pipeline")

endmodule
